// ===== sv/lpmr_pkg.sv =====
// shared types, constants and helpers of the longest prefix match router
package lpmr_pkg;

  // table and field sizing
  localparam int MAX_ROUTES = 64;
  localparam int NUM_IFACES = 16;
  localparam int CNT_W      = $clog2(MAX_ROUTES + 1);
  localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 6;
  localparam int IFACE_W    = 4;
  localparam int TTL_W      = 8;
  localparam int STATUS_W   = 3;

  // command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

  // function codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_ROUTE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FORWARDED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TTL_EXPIRED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd4;

  // input word
  typedef struct packed {
    logic               func;
    logic [ADDR_W-1:0]  rt_prefix;
    logic [LEN_W-1:0]   prefix_len;
    logic               hop_present;
    logic [ADDR_W-1:0]  hop_addr;
    logic [IFACE_W-1:0] iface_sel;
    logic [ADDR_W-1:0]  dst_ip;
    logic [TTL_W-1:0]   ttl_in;
  } lpmr_in_t;

  // result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IFACE_W-1:0]  out_iface;
    logic [ADDR_W-1:0]   next_hop_out;
    logic [TTL_W-1:0]    ttl_out;
  } lpmr_out_t;

  // one stored route
  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   len;
    logic               has_hop;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] iface;
  } lpmr_route_t;

  // classified command handed from front to back
  typedef struct packed {
    logic             is_route;
    logic             ttl_live;
    lpmr_route_t      entry;
    logic [ADDR_W-1:0] dst;
    logic [TTL_W-1:0] ttl;
  } lpmr_cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADD,
    BK_SCAN,
    BK_DONE
  } lpmr_bk_state_t;

  typedef logic [IFACE_W-1:0] lpmr_iface_tab_t [2**IFACE_W];

  // interface index reduced into range, worked out at elaboration
  function automatic lpmr_iface_tab_t build_iface_wrap();
    lpmr_iface_tab_t tab;
    for (int i = 0; i < 2**IFACE_W; i++) begin
      tab[i] = IFACE_W'(i % NUM_IFACES);
    end
    return tab;
  endfunction

  localparam lpmr_iface_tab_t IFACE_WRAP = build_iface_wrap();

  // high-order mask of len bits, len at most 32
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// ===== sv/lpmr_front.sv =====
// front end: takes input words, classifies them and queues commands
module lpmr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  lpmr_pkg::lpmr_in_t  in_word,
  output logic                cmd_push,
  output lpmr_pkg::lpmr_cmd_t cmd_data,
  input  logic                cmd_full
);

  lpmr_pkg::lpmr_cmd_t cmd_r;
  logic                vld_r;
  lpmr_pkg::lpmr_cmd_t cmd_nxt;
  logic                take;

  // classify: saturate length, wrap interface, flag live ttl
  always_comb begin
    cmd_nxt.is_route      = (in_word.func == lpmr_pkg::FUNC_ROUTE);
    cmd_nxt.ttl_live      = (in_word.ttl_in > lpmr_pkg::TTL_W'(1));
    cmd_nxt.entry.prefix  = in_word.rt_prefix;
    cmd_nxt.entry.len     = (in_word.prefix_len > lpmr_pkg::MAX_LEN) ?
                            lpmr_pkg::MAX_LEN : in_word.prefix_len;
    cmd_nxt.entry.has_hop = in_word.hop_present;
    cmd_nxt.entry.hop     = in_word.hop_addr;
    cmd_nxt.entry.iface   = lpmr_pkg::IFACE_WRAP[in_word.iface_sel];
    cmd_nxt.dst           = in_word.dst_ip;
    cmd_nxt.ttl           = in_word.ttl_in;
  end

  // one-word holding register in front of the queue
  assign in_full  = vld_r && cmd_full;
  assign take     = in_push && !in_full;
  assign cmd_push = vld_r && !cmd_full;
  assign cmd_data = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (cmd_push) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== sv/lpmr_fifo.sv =====
// short command queue between front and back
module lpmr_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpmr_pkg::lpmr_cmd_t wr_data,
  output logic                full,
  input  logic                pop,
  output lpmr_pkg::lpmr_cmd_t rd_data,
  output logic                empty
);

  lpmr_pkg::lpmr_cmd_t                slot_r [lpmr_pkg::FIFO_DEPTH];
  logic [lpmr_pkg::PTR_W-1:0]         wr_ptr_r;
  logic [lpmr_pkg::PTR_W-1:0]         rd_ptr_r;
  logic [lpmr_pkg::FCNT_W-1:0]        cnt_r;
  logic                               do_push;
  logic                               do_pop;

  assign full    = (cnt_r == lpmr_pkg::FCNT_W'(lpmr_pkg::FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == lpmr_pkg::PTR_W'(lpmr_pkg::FIFO_DEPTH - 1)) ?
                    '0 : wr_ptr_r + lpmr_pkg::PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == lpmr_pkg::PTR_W'(lpmr_pkg::FIFO_DEPTH - 1)) ?
                    '0 : rd_ptr_r + lpmr_pkg::PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + lpmr_pkg::FCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - lpmr_pkg::FCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/lpmr_back.sv =====
// back end: route table, sequential prefix scan and result register
module lpmr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  lpmr_pkg::lpmr_cmd_t cmd_data,
  output logic                cmd_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output lpmr_pkg::lpmr_out_t out_word
);

  lpmr_pkg::lpmr_route_t             tbl_mem [lpmr_pkg::MAX_ROUTES];

  lpmr_pkg::lpmr_bk_state_t          state_r, state_nxt;
  lpmr_pkg::lpmr_cmd_t               cur_r;
  logic [lpmr_pkg::CNT_W-1:0]        count_r;
  logic [lpmr_pkg::CNT_W-1:0]        idx_r;
  logic                              rd_vld_r;
  lpmr_pkg::lpmr_route_t             rd_ent_r;
  logic                              found_r;
  logic [lpmr_pkg::LEN_W-1:0]        best_len_r;
  logic [lpmr_pkg::IFACE_W-1:0]      best_iface_r;
  logic                              best_has_hop_r;
  logic [lpmr_pkg::ADDR_W-1:0]       best_hop_r;
  logic                              out_vld_r;
  lpmr_pkg::lpmr_out_t               out_word_r;
  lpmr_pkg::lpmr_out_t               out_word_nxt;

  logic                              slot_free;
  logic                              tbl_full;
  logic                              issue;
  logic                              mem_we;
  logic                              out_load;
  logic                              hit;
  logic [lpmr_pkg::ADDR_W-1:0]       mask;

  assign slot_free = !out_vld_r || out_pop;
  assign tbl_full  = (count_r == lpmr_pkg::CNT_W'(lpmr_pkg::MAX_ROUTES));
  assign out_empty = !out_vld_r;
  assign out_word  = out_word_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpmr_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          if (!cmd_data.is_route) begin
            state_nxt = lpmr_pkg::BK_ADD;
          end else if (cmd_data.ttl_live) begin
            state_nxt = lpmr_pkg::BK_SCAN;
          end else begin
            state_nxt = lpmr_pkg::BK_DONE;
          end
        end
      end
      lpmr_pkg::BK_ADD: begin
        if (slot_free) begin
          state_nxt = lpmr_pkg::BK_IDLE;
        end
      end
      lpmr_pkg::BK_SCAN: begin
        if (!(idx_r < count_r) && !rd_vld_r) begin
          state_nxt = lpmr_pkg::BK_DONE;
        end
      end
      lpmr_pkg::BK_DONE: begin
        if (slot_free) begin
          state_nxt = lpmr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lpmr_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs and result word
  always_comb begin
    cmd_pop      = 1'b0;
    issue        = 1'b0;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    out_word_nxt = '0;
    case (state_r)
      lpmr_pkg::BK_IDLE: begin
        cmd_pop = !cmd_empty;
      end
      lpmr_pkg::BK_ADD: begin
        out_load            = slot_free;
        mem_we              = slot_free && !tbl_full;
        out_word_nxt.status = tbl_full ? lpmr_pkg::ST_TABLE_FULL : lpmr_pkg::ST_ADDED;
      end
      lpmr_pkg::BK_SCAN: begin
        issue = (idx_r < count_r);
      end
      lpmr_pkg::BK_DONE: begin
        out_load = slot_free;
        if (!cur_r.ttl_live) begin
          out_word_nxt.status = lpmr_pkg::ST_TTL_EXPIRED;
        end else if (!found_r) begin
          out_word_nxt.status = lpmr_pkg::ST_NO_ROUTE;
        end else begin
          out_word_nxt.status       = lpmr_pkg::ST_FORWARDED;
          out_word_nxt.out_iface    = best_iface_r;
          out_word_nxt.next_hop_out = best_has_hop_r ? best_hop_r : cur_r.dst;
          out_word_nxt.ttl_out      = cur_r.ttl - lpmr_pkg::TTL_W'(1);
        end
      end
      default: ;
    endcase
  end

  // compare of the entry read last cycle against the destination
  assign mask = lpmr_pkg::len_mask(rd_ent_r.len);
  assign hit  = rd_vld_r && ((cur_r.dst & mask) == (rd_ent_r.prefix & mask)) &&
                (!found_r || (rd_ent_r.len > best_len_r));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lpmr_pkg::BK_IDLE;
      count_r   <= '0;
      idx_r     <= '0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (mem_we) begin
        count_r <= count_r + lpmr_pkg::CNT_W'(1);
      end
      if (cmd_pop) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (issue) begin
          idx_r <= idx_r + lpmr_pkg::CNT_W'(1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd_data;
    end
    if (hit) begin
      best_len_r     <= rd_ent_r.len;
      best_iface_r   <= rd_ent_r.iface;
      best_has_hop_r <= rd_ent_r.has_hop;
      best_hop_r     <= rd_ent_r.hop;
    end
    if (out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  // route table: one write port at the fill count, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[count_r[lpmr_pkg::IDX_W-1:0]] <= cur_r.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ent_r <= tbl_mem[idx_r[lpmr_pkg::IDX_W-1:0]];
    end
  end

endmodule

// ===== sv/ipv4_longest_prefix_router_top.sv =====
// top level of the ipv4 longest prefix match router
// an add word, or a lookup with ttl of one or less, passes straight to the result
//   register; a lookup first scans the N stored routes, one entry a cycle over the
//   single read port of the route memory; the back end works one command at a time,
//   and later words wait in the front holding register and the command queue
// reset: synchronous, active low; empties both queues and the table (fill count 0)
module ipv4_longest_prefix_router_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  lpmr_pkg::lpmr_in_t  in_word,
  output logic                out_empty,
  input  logic                out_pop,
  output lpmr_pkg::lpmr_out_t out_word
);

  logic                cmd_push;
  logic                cmd_full;
  lpmr_pkg::lpmr_cmd_t cmd_wr;
  lpmr_pkg::lpmr_cmd_t cmd_rd;
  logic                cmd_empty;
  logic                cmd_pop;

  // front end
  lpmr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_word  (in_word),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wr),
    .cmd_full (cmd_full)
  );

  // command queue
  lpmr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  // back end
  lpmr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ===== sv/lpmr_checker.sv =====
// port level checks of the router, bound to the top level
module lpmr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input lpmr_pkg::lpmr_out_t out_word
);

  // nothing waits on the result side just after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result word present right after reset");

  // a waiting result word holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("waiting result word changed");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_word.status == lpmr_pkg::ST_ADDED ||
                    out_word.status == lpmr_pkg::ST_FORWARDED ||
                    out_word.status == lpmr_pkg::ST_NO_ROUTE ||
                    out_word.status == lpmr_pkg::ST_TTL_EXPIRED ||
                    out_word.status == lpmr_pkg::ST_TABLE_FULL))
    else $error("undefined status code");

  // words that are not forwarded carry zero payload
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.status != lpmr_pkg::ST_FORWARDED) |->
      (out_word.out_iface == '0 && out_word.next_hop_out == '0 &&
       out_word.ttl_out == '0))
    else $error("non-forwarded word with payload");

  // a forwarded word left with a ttl of at least one
  a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.status == lpmr_pkg::ST_FORWARDED) |->
      (out_word.ttl_out != '0))
    else $error("forwarded word with zero ttl");

endmodule

bind ipv4_longest_prefix_router_top lpmr_checker u_lpmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_word  (out_word)
);
